### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, sampled on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every sampled edge
`define ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// cause on this edge implies effect on the next one
`define ASSERT_NEXT(lbl, cause, effect) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("assertion failed");

`endif

### rtl/core/q2e_pkg.sv
// ---------------------------------------------------------------------------
// q2e_pkg
// Shared widths, cell state types and the CORDIC angle table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package q2e_pkg;

    localparam int CW         = 40;   // CORDIC x/y width
    localparam int ZW         = 27;   // angle accumulator, deg * 2^16
    localparam int PW         = 36;   // product sums
    localparam int SQ_STEPS   = 31;   // isqrt digit cells
    localparam int COR_STEPS  = 16;   // CORDIC iteration cells
    localparam int PIPE_DEPTH = 3 + SQ_STEPS + 1 + COR_STEPS + 1;

    typedef struct packed {
        logic [60:0] v;     // remainder
        logic [62:0] res;   // partial root
    } sqrt_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 hold;  // axis case, angle already final
    } cordic_t;

    // atan(2^-i) in degrees, 16 fraction bits
    localparam logic signed [ZW-1:0] ATAN_TAB [COR_STEPS] = '{
        27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
        27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
        27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
        27'sd917,     27'sd458,     27'sd229,    27'sd115
    };

endpackage

### rtl/core/q2e_sqrt_cell.sv
// ---------------------------------------------------------------------------
// q2e_sqrt_cell
// One digit of the restoring integer square root, registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module q2e_sqrt_cell (
    input  logic              clk,
    input  logic              en,
    input  logic [4:0]        step,
    input  q2e_pkg::sqrt_t    din,
    output q2e_pkg::sqrt_t    dout
);

    logic [5:0]     sh;
    logic [62:0]    bit_w;
    logic [63:0]    sum;
    q2e_pkg::sqrt_t nxt;

    always_comb
    begin
        sh    = 6'(6'd62 - {step, 1'b0});
        bit_w = 63'(1) << sh;
        sum   = {1'b0, din.res} + {1'b0, bit_w};
        if ({3'b000, din.v} >= sum)
        begin
            nxt.v   = 61'({3'b000, din.v} - sum);
            nxt.res = (din.res >> 1) + bit_w;
        end
        else
        begin
            nxt.v   = din.v;
            nxt.res = din.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout <= nxt;
        end
    end

endmodule

### rtl/core/q2e_cordic_cell.sv
// ---------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring CORDIC micro-rotation, registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module q2e_cordic_cell (
    input  logic                clk,
    input  logic                en,
    input  logic [3:0]          step,
    input  q2e_pkg::cordic_t    din,
    output q2e_pkg::cordic_t    dout
);

    logic signed [q2e_pkg::CW-1:0] dx;
    logic signed [q2e_pkg::CW-1:0] dy;
    q2e_pkg::cordic_t              nxt;

    always_comb
    begin
        dx  = din.y >>> step;
        dy  = din.x >>> step;
        nxt = din;
        if (!din.hold)
        begin
            if (din.y > 0)
            begin
                nxt.x = din.x + dx;
                nxt.y = din.y - dy;
                nxt.z = din.z + q2e_pkg::ATAN_TAB[step];
            end
            else
            begin
                nxt.x = din.x - dx;
                nxt.y = din.y + dy;
                nxt.z = din.z - q2e_pkg::ATAN_TAB[step];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout <= nxt;
        end
    end

endmodule

### rtl/core/quaternion_to_euler.sv
// ---------------------------------------------------------------------------
// quaternion_to_euler
// Unit quaternion (Q1.14) to roll, pitch, yaw in degrees (7 fraction bits).
// ---------------------------------------------------------------------------
// channel | dir | fields (tdata, low bit first)              | tuser
// s_axis  | in  | quat_x[15:0] quat_y quat_z quat_w (64 bits) | -
// m_axis  | out | roll_deg[15:0] pitch_deg[14:0] yaw_deg[15:0] pad (48) | pitch_clamped
//
// One transaction per cycle sustained while the skid stage is empty;
// stages up to the output register: products, sums, m*m, 31 isqrt digit
// cells, axis pre-rotation, 16 CORDIC cells, rounding.
// rst_n (async, active low) clears only the valid bits; no clearing pass.
// The pipeline advances while the skid stage is empty, so one result may
// wait in the output register while items keep flowing in.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_to_euler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // roll_deg, pitch_deg, yaw_deg, zero pad
    output logic        m_tuser    // pitch_clamped
);

    localparam int LROLL  = 0;
    localparam int LPITCH = 1;
    localparam int LYAW   = 2;

    typedef struct packed {
        logic signed [q2e_pkg::PW-1:0] sr;
        logic signed [q2e_pkg::PW-1:0] cr;
        logic signed [q2e_pkg::PW-1:0] sy;
        logic signed [q2e_pkg::PW-1:0] cy;
        logic [29:0]                   m;
        logic                          neg;
        logic                          clamp;
    } side_t;

    typedef struct packed {
        logic neg;
        logic clamp;
    } flag_t;

    // global advance: pipeline moves while skid is empty
    logic adv;
    logic [q2e_pkg::PIPE_DEPTH-1:0] vld_reg;
    logic [q2e_pkg::PIPE_DEPTH-1:0] vld_next;

    // stage A: products
    logic signed [31:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg;
    logic signed [31:0] p_wz_reg, p_xy_reg, p_zz_reg, p_wy_reg, p_zx_reg;

    // stage B: sums
    side_t side_b_next;
    side_t side_b_reg;

    // stage C and isqrt chain
    side_t          side_reg [q2e_pkg::SQ_STEPS+1];
    q2e_pkg::sqrt_t sq_in_reg;
    q2e_pkg::sqrt_t sq_out [q2e_pkg::SQ_STEPS];
    logic [59:0]    mm;

    // pre-rotation and CORDIC chains
    q2e_pkg::cordic_t co_in_next [3];
    q2e_pkg::cordic_t co_in_reg  [3];
    q2e_pkg::cordic_t co_out     [3][q2e_pkg::COR_STEPS];
    flag_t            flg_reg    [q2e_pkg::COR_STEPS+1];

    // rounding stage
    logic [15:0] o_roll_reg;
    logic [14:0] o_pitch_reg;
    logic [15:0] o_yaw_reg;
    logic        o_clamp_reg;
    logic [15:0] o_roll_next;
    logic [14:0] o_pitch_next;
    logic [15:0] o_yaw_next;
    logic signed [17:0] pr;

    // output register and skid
    logic        out_v_reg, out_v_next;
    logic        skid_v_reg, skid_v_next;
    logic [47:0] out_d_reg, skid_d_reg;
    logic        out_u_reg, skid_u_reg;
    logic [47:0] p_data;
    logic        p_v;

    function automatic q2e_pkg::cordic_t pre_rot(
        input logic signed [q2e_pkg::CW-1:0] x,
        input logic signed [q2e_pkg::CW-1:0] y
    );
        q2e_pkg::cordic_t r;
        r.x    = x;
        r.y    = y;
        r.z    = '0;
        r.hold = 1'b0;
        if (y == 0)
        begin
            r.hold = 1'b1;
            r.z    = (x >= 0) ? 27'sd0 : 27'sd11796480;
        end
        else if (x == 0)
        begin
            r.hold = 1'b1;
            r.z    = (y > 0) ? 27'sd5898240 : -27'sd5898240;
        end
        else if (x < 0)
        begin
            if (y >= 0)
            begin
                r.x = y;
                r.y = -x;
                r.z = 27'sd5898240;
            end
            else
            begin
                r.x = -y;
                r.y = x;
                r.z = -27'sd5898240;
            end
        end
        return r;
    endfunction

    // round half up to 7 fraction bits, then saturate
    function automatic logic signed [17:0] to_out(
        input logic signed [q2e_pkg::ZW-1:0] z,
        input logic signed [17:0]            lim
    );
        logic signed [q2e_pkg::ZW-1:0] t;
        logic signed [17:0]            r;
        t = (z + 27'sd256) >>> 9;
        r = 18'(t);
        if (r > lim)
        begin
            r = lim;
        end
        if (r < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

    assign adv      = ~skid_v_reg;
    assign s_tready = adv;
    assign vld_next = {vld_reg[q2e_pkg::PIPE_DEPTH-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= vld_next;
            end
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    // ---- stage A: nine 16x16 products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_wx_reg <= $signed(s_tdata[63:48]) * $signed(s_tdata[15:0]);
            p_yz_reg <= $signed(s_tdata[31:16]) * $signed(s_tdata[47:32]);
            p_xx_reg <= $signed(s_tdata[15:0])  * $signed(s_tdata[15:0]);
            p_yy_reg <= $signed(s_tdata[31:16]) * $signed(s_tdata[31:16]);
            p_wz_reg <= $signed(s_tdata[63:48]) * $signed(s_tdata[47:32]);
            p_xy_reg <= $signed(s_tdata[15:0])  * $signed(s_tdata[31:16]);
            p_zz_reg <= $signed(s_tdata[47:32]) * $signed(s_tdata[47:32]);
            p_wy_reg <= $signed(s_tdata[63:48]) * $signed(s_tdata[31:16]);
            p_zx_reg <= $signed(s_tdata[47:32]) * $signed(s_tdata[15:0]);
        end
    end

    // ---- stage B: numerators, denominators, pitch sine
    always_comb
    begin
        logic signed [q2e_pkg::PW-1:0] sp;
        logic [q2e_pkg::PW-1:0]        mag;
        side_b_next.sr = (36'(p_wx_reg) + 36'(p_yz_reg)) <<< 1;
        side_b_next.cr = 36'sd268435456 - ((36'(p_xx_reg) + 36'(p_yy_reg)) <<< 1);
        side_b_next.sy = (36'(p_wz_reg) + 36'(p_xy_reg)) <<< 1;
        side_b_next.cy = 36'sd268435456 - ((36'(p_yy_reg) + 36'(p_zz_reg)) <<< 1);
        sp  = (36'(p_wy_reg) - 36'(p_zx_reg)) <<< 1;
        mag = (sp < 0) ? 36'(-sp) : 36'(sp);
        side_b_next.neg   = sp[q2e_pkg::PW-1];
        side_b_next.clamp = (sp >= 36'sd268435456) || (sp <= -36'sd268435456);
        side_b_next.m     = {mag[27:0], 2'b00};  // Q28 -> Q30
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_b_reg <= side_b_next;
        end
    end

    // ---- stage C: radicand 2^60 - m^2
    assign mm = side_b_reg.m * side_b_reg.m;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_in_reg.v   <= 61'(61'h1 << 60) - {1'b0, mm};
            sq_in_reg.res <= '0;
            side_reg[0]   <= side_b_reg;
            for (int k = 0; k < q2e_pkg::SQ_STEPS; k++)
            begin
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // ---- isqrt chain, one root bit per cell
    // radicand is at most 2^60, so the digit walk starts at bit 2^60 and
    // ends at bit 2^0
    for (genvar k = 0; k < q2e_pkg::SQ_STEPS; k++)
    begin : g_sq
        if (k == 0)
        begin : g_first
            q2e_sqrt_cell u_cell (
                .clk  (clk),
                .en   (adv),
                .step (5'(k + 1)),
                .din  (sq_in_reg),
                .dout (sq_out[k])
            );
        end
        else
        begin : g_rest
            q2e_sqrt_cell u_cell (
                .clk  (clk),
                .en   (adv),
                .step (5'(k + 1)),
                .din  (sq_out[k-1]),
                .dout (sq_out[k])
            );
        end
    end

    // ---- axis cases and quadrant pre-rotation for all three lanes
    always_comb
    begin
        side_t s;
        s = side_reg[q2e_pkg::SQ_STEPS];
        co_in_next[LROLL]  = pre_rot(40'(s.cr), 40'(s.sr));
        co_in_next[LYAW]   = pre_rot(40'(s.cy), 40'(s.sy));
        co_in_next[LPITCH] = pre_rot(
            {9'b0, sq_out[q2e_pkg::SQ_STEPS-1].res[30:0]}, {10'b0, s.m});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 3; l++)
            begin
                co_in_reg[l] <= co_in_next[l];
            end
            flg_reg[0].neg   <= side_reg[q2e_pkg::SQ_STEPS].neg;
            flg_reg[0].clamp <= side_reg[q2e_pkg::SQ_STEPS].clamp;
            for (int j = 0; j < q2e_pkg::COR_STEPS; j++)
            begin
                flg_reg[j+1] <= flg_reg[j];
            end
        end
    end

    // ---- CORDIC chains: three lanes of identical cells
    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        for (genvar j = 0; j < q2e_pkg::COR_STEPS; j++)
        begin : g_it
            if (j == 0)
            begin : g_first
                q2e_cordic_cell u_cell (
                    .clk  (clk),
                    .en   (adv),
                    .step (4'(j)),
                    .din  (co_in_reg[l]),
                    .dout (co_out[l][j])
                );
            end
            else
            begin : g_rest
                q2e_cordic_cell u_cell (
                    .clk  (clk),
                    .en   (adv),
                    .step (4'(j)),
                    .din  (co_out[l][j-1]),
                    .dout (co_out[l][j])
                );
            end
        end
    end

    // ---- rounding, saturation, pitch sign and clamp override
    always_comb
    begin
        flag_t f;
        f            = flg_reg[q2e_pkg::COR_STEPS];
        o_roll_next  = 16'(to_out(co_out[LROLL][q2e_pkg::COR_STEPS-1].z, 18'sd23040));
        o_yaw_next   = 16'(to_out(co_out[LYAW][q2e_pkg::COR_STEPS-1].z, 18'sd23040));
        pr           = to_out(co_out[LPITCH][q2e_pkg::COR_STEPS-1].z, 18'sd11520);
        if (f.neg)
        begin
            pr = -pr;
        end
        if (f.clamp)
        begin
            pr = f.neg ? -18'sd11520 : 18'sd11520;
        end
        o_pitch_next = 15'(pr);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_roll_reg  <= o_roll_next;
            o_pitch_reg <= o_pitch_next;
            o_yaw_reg   <= o_yaw_next;
            o_clamp_reg <= flg_reg[q2e_pkg::COR_STEPS].clamp;
        end
    end

    // ---- output register with skid stage
    assign p_v    = vld_reg[q2e_pkg::PIPE_DEPTH-1] & adv;
    assign p_data = {1'b0, o_yaw_reg, o_pitch_reg, o_roll_reg};

    always_comb
    begin
        out_v_next  = out_v_reg;
        skid_v_next = skid_v_reg;
        if (out_v_reg && !m_tready)
        begin
            if (p_v)
            begin
                skid_v_next = 1'b1;
            end
        end
        else if (skid_v_reg)
        begin
            out_v_next  = 1'b1;
            skid_v_next = 1'b0;
        end
        else
        begin
            out_v_next = p_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_v_reg && !m_tready)
        begin
            if (p_v)
            begin
                skid_d_reg <= p_data;
                skid_u_reg <= o_clamp_reg;
            end
        end
        else if (skid_v_reg)
        begin
            out_d_reg <= skid_d_reg;
            out_u_reg <= skid_u_reg;
        end
        else
        begin
            out_d_reg <= p_data;
            out_u_reg <= o_clamp_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
    assign m_tuser  = out_u_reg;

`include "assert_macros.svh"

    // skid only fills behind a waiting output
    `ASSERT_ALWAYS(a_skid_behind_out, !skid_v_reg || out_v_reg)
    // a result arriving at a stalled output must land in the skid
    `ASSERT_NEXT(a_skid_catch, out_v_reg && !m_tready && p_v, skid_v_reg)
    // a clamped pitch is exactly plus or minus ninety degrees
    `ASSERT_ALWAYS(a_clamp_pitch, !(m_tvalid && m_tuser) ||
        (m_tdata[30:16] == 15'd11520) || (m_tdata[30:16] == 15'h5300))

endmodule

### tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for quaternion_to_euler: a bit-exact angle predictor
// runs beside the block, stimulus is bursty and the sink stalls at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int QFRAC      = 14;
    localparam int ITER_COUNT = 16;
    localparam int LATENCY    = 52;
    localparam int IDLE_LIMIT = 4000;
    localparam int N_RANDOM   = 1900;
    localparam longint DEG1   = 65536;
    localparam int ROLL_MAX   = 23040;
    localparam int PITCH_MAX  = 11520;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } quat_t;

    typedef struct packed {
        logic               clamped;
        logic signed [15:0] yaw;
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
    } euler_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // quat_x, quat_y, quat_z, quat_w
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // roll_deg, pitch_deg, yaw_deg, zero pad
    logic        m_tuser;   // pitch_clamped

    quat_t  quat_pending[$];
    euler_t angles_due[$];
    int     errors;
    int     checked;
    int     clamp_seen;
    bit     stim_done;
    int     idle_cycles;
    int     gap_left;
    int     burst_left;
    logic   s_fire_q;

    quaternion_to_euler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // atan table, degrees with 16 fraction bits
    function automatic longint atan_deg(int i);
        longint tab[16];
        tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                14668, 7334, 3667, 1833, 917, 458, 229, 115};
        return tab[i];
    endfunction

    function automatic longint vector_angle(longint xi, longint yi);
        longint xr;
        longint yr;
        longint za;
        longint tmp;
        longint dx;
        longint dy;
        xr = xi;
        yr = yi;
        za = 0;
        if (yr == 0)
            return (xr >= 0) ? 0 : 180 * DEG1;
        if (xr == 0)
            return (yr > 0) ? 90 * DEG1 : -90 * DEG1;
        // fold left half-plane by a quarter turn
        if (xr < 0)
        begin
            if (yr >= 0)
            begin
                tmp = xr; xr = yr; yr = -tmp; za = 90 * DEG1;
            end
            else
            begin
                tmp = xr; xr = -yr; yr = tmp; za = -90 * DEG1;
            end
        end
        for (int i = 0; i < ITER_COUNT; i++)
        begin
            dx = yr >>> i;
            dy = xr >>> i;
            if (yr > 0)
            begin
                xr += dx; yr -= dy; za += atan_deg(i);
            end
            else
            begin
                xr -= dx; yr += dy; za -= atan_deg(i);
            end
        end
        return za;
    endfunction

    // degrees*65536 to degrees*128, round half up, then clip
    function automatic longint deg_round(longint v, longint lim);
        longint r;
        r = (v + 256) >>> 9;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic longint ratio_angle(longint num, longint den);
        // 2*QFRAC = 28 fraction bits, under 30, so no pre-shift
        return vector_angle(den, num);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic euler_t predict_angles(quat_t q);
        euler_t e;
        longint qx, qy, qz, qw, one, sr, cr, sy, cy, sp, p;
        longint unsigned m;
        qx = q.x; qy = q.y; qz = q.z; qw = q.w;
        one = longint'(1) << (2 * QFRAC);
        sr = 2 * (qw * qx + qy * qz);
        cr = one - 2 * (qx * qx + qy * qy);
        sy = 2 * (qw * qz + qx * qy);
        cy = one - 2 * (qy * qy + qz * qz);
        sp = 2 * (qw * qy - qz * qx);
        e.roll = 16'(deg_round(ratio_angle(sr, cr), ROLL_MAX));
        e.yaw  = 16'(deg_round(ratio_angle(sy, cy), ROLL_MAX));
        if (sp >= one || sp <= -one)
        begin
            e.pitch   = (sp > 0) ? 15'(PITCH_MAX) : 15'(-PITCH_MAX);
            e.clamped = 1'b1;
        end
        else
        begin
            m = longint'(sp < 0 ? -sp : sp) << (30 - 2 * QFRAC);
            p = deg_round(vector_angle(int_sqrt((64'd1 << 60) - m * m), longint'(m)),
                          PITCH_MAX);
            if (sp < 0) p = -p;
            e.pitch   = 15'(p);
            e.clamped = 1'b0;
        end
        return e;
    endfunction

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sh8000;
            3: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // roughly unit quaternion, normalized in real arithmetic
    function automatic quat_t rand_unit();
        quat_t q;
        real a, b, c, d, n;
        a = $itor($signed($urandom_range(0, 2000)) - 1000);
        b = $itor($signed($urandom_range(0, 2000)) - 1000);
        c = $itor($signed($urandom_range(0, 2000)) - 1000);
        d = $itor($signed($urandom_range(0, 2000)) - 1000);
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
        begin
            a = 1000.0; n = 1000.0;
        end
        q.x = 16'($rtoi(a / n * 16384.0));
        q.y = 16'($rtoi(b / n * 16384.0));
        q.z = 16'($rtoi(c / n * 16384.0));
        q.w = 16'($rtoi(d / n * 16384.0));
        return q;
    endfunction

    function automatic quat_t mk(int x, int y, int z, int w);
        quat_t q;
        q.x = 16'(x); q.y = 16'(y); q.z = 16'(z); q.w = 16'(w);
        return q;
    endfunction

    // append one quaternion to the stimulus queue
    function automatic void add_pending(quat_t q);
        quat_pending.insert(quat_pending.size(), q);
    endfunction

    initial
    begin
        quat_t q;
        int h;
        h = 11585;  // 1/sqrt(2) in Q14
        // identity, axis turns, gimbal lock both ways, zero vector, extremes
        add_pending(mk(0, 0, 0, 16384));
        add_pending(mk(0, 0, 0, -16384));
        add_pending(mk(16384, 0, 0, 0));
        add_pending(mk(0, 16384, 0, 0));
        add_pending(mk(0, 0, 16384, 0));
        add_pending(mk(0, h, 0, h));
        add_pending(mk(0, -h, 0, h));
        add_pending(mk(0, 8192, 0, 8192));
        add_pending(mk(0, -8192, 0, 8192));
        add_pending(mk(h, 0, 0, h));
        add_pending(mk(-h, 0, 0, h));
        add_pending(mk(0, 0, h, h));
        add_pending(mk(0, 0, -h, h));
        add_pending(mk(8192, 8192, 8192, 8192));
        add_pending(mk(-8192, 8192, -8192, 8192));
        add_pending(mk(0, 0, 0, 0));
        add_pending(mk(-32768, -32768, -32768, -32768));
        add_pending(mk(32767, 32767, 32767, 32767));
        add_pending(mk(-32768, 32767, 0, -1));
        add_pending(mk(8192, 0, 0, 0));   // zero sine, positive cosine
        add_pending(mk(0, 0, 0, 1));
        add_pending(mk(-1, 1, -1, 1));
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if ($urandom_range(0, 3) != 0)
                q = rand_unit();
            else
            begin
                q.x = rand_comp(); q.y = rand_comp();
                q.z = rand_comp(); q.w = rand_comp();
            end
            add_pending(q);
        end
        stim_done = 1'b1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver: bursts and gaps, changes on the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            gap_left   <= 0;
            burst_left <= 0;
        end
        else if (!s_tvalid || s_fire_q)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (quat_pending.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= quat_pending.pop_front();
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // transaction taken at the last rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_fire_q   <= 1'b0;
        end
        else
        begin
            s_fire_q   <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                angles_due.insert(angles_due.size(), predict_angles(quat_t'(s_tdata)));
        end
    end

    // sink stall pattern: long open stretches, then random choppy phases
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            case (($time / 20000) % 4)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 1) != 0);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
    end

    // monitor
    always @(posedge clk)
    begin
        euler_t got;
        euler_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.roll    = m_tdata[15:0];
            got.pitch   = m_tdata[30:16];
            got.yaw     = m_tdata[46:31];
            got.clamped = m_tuser;
            if (angles_due.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = angles_due.pop_front();
                checked++;
                if (got.clamped) clamp_seen++;
                if (got.roll !== want.roll)
                begin
                    $display("%0t: roll exp %0d got %0d", $time, want.roll, got.roll);
                    errors++;
                end
                if (got.pitch !== want.pitch)
                begin
                    $display("%0t: pitch exp %0d got %0d", $time, want.pitch, got.pitch);
                    errors++;
                end
                if (got.yaw !== want.yaw)
                begin
                    $display("%0t: yaw exp %0d got %0d", $time, want.yaw, got.yaw);
                    errors++;
                end
                if (got.clamped !== want.clamped)
                begin
                    $display("%0t: clamp exp %0b got %0b", $time, want.clamped,
                             got.clamped);
                    errors++;
                end
            end
        end
    end

    // watchdog and end of run
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        wait (stim_done && rst_n);
        wait (quat_pending.size() == 0 && !s_tvalid);
        wait (angles_due.size() == 0);
        repeat (LATENCY + 8) @(posedge clk);
        $display("checked %0d angle sets, %0d with pitch clamped, under bursty input",
                 checked, clamp_seen);
        $display("and random output back-pressure");
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

### quaternion_to_euler.f
+incdir+rtl/core
rtl/core/q2e_pkg.sv
rtl/core/q2e_sqrt_cell.sv
rtl/core/q2e_cordic_cell.sv
rtl/core/quaternion_to_euler.sv
tb/sv/tb_top.sv
